### src/lsgr_pkg.sv
// Shared types, constants and helper functions for the LED strip gradient renderer.
package lsgr_pkg;

  // Defaults for the top-level parameters
  localparam int LED_COUNT_DEF = 64;
  localparam int MAX_STOPS_DEF = 16;

  // Field widths fixed by the stream format
  localparam int PCT_W  = 7;
  localparam int CH_W   = 8;
  localparam int IDX_W  = 6;
  localparam int MIX_W  = 15;
  localparam int MUL_W  = 13;
  localparam int PROD_W = 28;

  // Full scale of a stop position and of the blend weight
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // x / 100 == (x * 5243) >> 19 for every x below 43690
  localparam logic [MUL_W-1:0] DIV100_MUL   = 13'd5243;
  localparam int               DIV100_SHIFT = 19;

  // One gradient stop, packed as it arrives on the input stream
  typedef struct packed {
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic [PCT_W-1:0] pct;
  } stop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD_P,
    ST_RD_N,
    ST_SETUP,
    ST_DIV,
    ST_SWEEP,
    ST_NEXT,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic store;
    logic seg_init;
    logic rd_p;
    logic rd_n;
    logic setup;
    logic sweep;
    logic seg_next;
    logic emit_init;
    logic emit;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic count_zero;
    logic more_segs;
    logic div_done;
    logic sweep_done;
    logic emit_done;
  } stat_t;

  // Weighted sum of two channel values, weight t on the next one
  function automatic logic [MIX_W-1:0] mix(input logic [CH_W-1:0]  pc,
                                           input logic [CH_W-1:0]  nc,
                                           input logic [PCT_W-1:0] t);
    logic [MIX_W-1:0] lo;
    logic [MIX_W-1:0] hi;
    lo = MIX_W'(pc) * MIX_W'(PCT_FULL - t);
    hi = MIX_W'(nc) * MIX_W'(t);
    return lo + hi;
  endfunction

  // Truncating divide by 100 through a reciprocal multiply
  function automatic logic [CH_W-1:0] div100(input logic [MIX_W-1:0] x);
    logic [PROD_W-1:0] pr;
    pr = PROD_W'(x) * PROD_W'(DIV100_MUL);
    return pr[DIV100_SHIFT +: CH_W];
  endfunction

endpackage

### src/lsgr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module lsgr_div #(
  parameter int W = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int CntW = $clog2(W);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    dvd_q;
  logic [W-1:0]    dvs_q;
  logic [W-1:0]    rem_q;
  logic [W:0]      shifted;
  logic            ge;
  logic [W:0]      diff;

  // Shift in the next dividend bit and trial-subtract
  assign shifted = {rem_q, dvd_q[W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};
  assign done_o  = busy_q && (cnt_q == CntW'(W - 1));
  assign quot_o  = dvd_q;
  assign rem_o   = rem_q;

  // Control: busy flag and bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: quotient shifts into the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[W-2:0], ge};
      rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
    end
  end

endmodule

### src/lsgr_dp.sv
// Datapath: stop store, segment setup, blend pipeline, pixel store and output register.
module lsgr_dp #(
  parameter int LedCount = lsgr_pkg::LED_COUNT_DEF,
  parameter int MaxStops = lsgr_pkg::MAX_STOPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lsgr_pkg::cmd_t              cmd_i,
  output lsgr_pkg::stat_t             stat_o,
  input  lsgr_pkg::stop_t             stop_i,
  input  logic                        m_ready_i,
  output logic                        m_valid_o,
  output logic [lsgr_pkg::IDX_W-1:0]  led_index_o,
  output logic [lsgr_pkg::CH_W-1:0]   led_red_o,
  output logic [lsgr_pkg::CH_W-1:0]   led_green_o,
  output logic [lsgr_pkg::CH_W-1:0]   led_blue_o,
  output logic                        last_led_o,
  output logic                        stops_dropped_o
);
  import lsgr_pkg::*;

  localparam int AW   = $clog2(MaxStops);
  localparam int CW   = $clog2(MaxStops + 1);
  localparam int IdxW = $clog2(LedCount);
  localparam int JW   = $clog2(LedCount + 1);
  localparam int PosN = int'(PCT_FULL) + 1;
  localparam int PxW  = 3 * CH_W;

  // Percent to LED position table, filled at elaboration
  function automatic logic [PosN*JW-1:0] build_pos_tab();
    logic [PosN*JW-1:0] tab;
    tab = '0;
    for (int i = 0; i < PosN; i++) begin
      tab[i*JW +: JW] = JW'(i * LedCount / 100);
    end
    return tab;
  endfunction

  localparam logic [PosN*JW-1:0] PosTab = build_pos_tab();

  function automatic logic [JW-1:0] pos_of(input logic [PCT_W-1:0] pct);
    return PosTab[int'(pct)*JW +: JW];
  endfunction

  // Stop store and bookkeeping
  stop_t           stop_mem [MaxStops];
  stop_t           rd_stop_q;
  stop_t           stop_sat;
  logic [CW-1:0]   count_q;
  logic            ovf_q;
  logic [CW-1:0]   k_q;
  logic [CW-1:0]   km1;
  logic [AW-1:0]   rd_addr;
  logic            room;

  // Segment registers
  stop_t           p_q;
  stop_t           n_q;
  logic [JW-1:0]   a_q;
  logic [JW-1:0]   b_q;
  logic [JW-1:0]   j_q;
  logic [JW-1:0]   end_q;
  logic [PCT_W:0]  t_q;
  logic [PCT_W-1:0] r_q;
  logic [JW-1:0]   a_new;
  logic [JW-1:0]   b_new;
  logic [JW-1:0]   ab_diff;
  logic            seg_first;
  logic            seg_last;

  // Divider results
  logic [PCT_W-1:0] q0;
  logic [PCT_W-1:0] r0;
  logic             div_done;

  // Sweep step
  logic             issue;
  logic             sweep_done;
  logic [PCT_W-1:0] t_eff;
  logic [PCT_W:0]   r_sum;
  logic             carry;
  logic [PCT_W:0]   d_ext;

  // Blend pipeline
  logic             mix_valid_q;
  logic [IdxW-1:0]  mix_idx_q;
  logic [MIX_W-1:0] mix_r_q;
  logic [MIX_W-1:0] mix_g_q;
  logic [MIX_W-1:0] mix_b_q;

  // Pixel store
  logic [PxW-1:0]      px_mem [LedCount];
  logic [LedCount-1:0] px_ok_q;
  logic [PxW-1:0]      rd_px_q;
  logic                rd_ok_q;

  // Output side
  logic [JW-1:0]   e_idx_q;
  logic            out_valid_q;
  logic [IdxW-1:0] out_idx_q;
  logic            e_issue;
  logic            e_more;
  logic [CW:0]     k_plus;

  // Saturate the position before it is stored
  always_comb begin
    stop_sat = stop_i;
    if (stop_i.pct > PCT_FULL) begin
      stop_sat.pct = PCT_FULL;
    end
  end

  assign room = count_q < CW'(MaxStops);
  assign km1  = k_q - CW'(1);

  // Previous stop at k-1, next stop at k (or stop 0 alone)
  always_comb begin
    if (cmd_i.rd_p) begin
      rd_addr = km1[AW-1:0];
    end else if (count_q == CW'(1)) begin
      rd_addr = '0;
    end else begin
      rd_addr = k_q[AW-1:0];
    end
  end

  // Stop store: write on accept while there is room, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && room) begin
      stop_mem[count_q[AW-1:0]] <= stop_sat;
    end
    if (cmd_i.rd_p || cmd_i.rd_n) begin
      rd_stop_q <= stop_mem[rd_addr];
    end
  end

  // Stop count, overflow flag and segment number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      k_q     <= '0;
    end else begin
      if (cmd_i.store) begin
        if (room) begin
          count_q <= count_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.seg_init) begin
        k_q <= CW'(1);
      end else if (cmd_i.seg_next) begin
        k_q <= k_q + CW'(1);
      end
    end
  end

  // Segment setup: LED span, fill bounds, divisor
  assign a_new     = pos_of(p_q.pct);
  assign b_new     = pos_of(rd_stop_q.pct);
  assign ab_diff   = b_new - a_new;
  assign seg_first = k_q == CW'(1);
  assign seg_last  = (count_q == CW'(1)) || (k_q == km1 + CW'(1) && k_q == count_q - CW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_n) begin
      p_q <= rd_stop_q;
    end
    if (cmd_i.setup) begin
      n_q   <= rd_stop_q;
      a_q   <= a_new;
      b_q   <= b_new;
      j_q   <= seg_first ? '0 : a_new;
      end_q <= seg_last ? JW'(LedCount) : ((b_new > a_new) ? b_new : a_new);
      t_q   <= '0;
      r_q   <= '0;
    end else if (issue) begin
      j_q <= j_q + JW'(1);
      if (j_q >= a_q && j_q < b_q) begin
        t_q <= t_q + (PCT_W + 1)'(q0) + (PCT_W + 1)'(carry);
        r_q <= carry ? PCT_W'(r_sum - d_ext) : r_sum[PCT_W-1:0];
      end
    end
  end

  // Step size 100 / (b - a) per segment
  lsgr_div #(
    .W (PCT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.setup),
    .dividend_i (PCT_FULL),
    .divisor_i  (PCT_W'(ab_diff)),
    .done_o     (div_done),
    .quot_o     (q0),
    .rem_o      (r0)
  );

  // Blend weight for the current LED
  assign sweep_done = j_q >= end_q;
  assign issue      = cmd_i.sweep && !sweep_done;
  assign d_ext      = (PCT_W + 1)'(b_q - a_q);
  assign r_sum      = (PCT_W + 1)'(r_q) + (PCT_W + 1)'(r0);
  assign carry      = r_sum >= d_ext;

  always_comb begin
    if (j_q < a_q) begin
      t_eff = '0;
    end else if (j_q < b_q) begin
      t_eff = t_q[PCT_W-1:0];
    end else begin
      t_eff = PCT_FULL;
    end
  end

  // Blend stage: weighted sums per channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_valid_q <= 1'b0;
    end else begin
      mix_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      mix_idx_q <= j_q[IdxW-1:0];
      mix_r_q   <= mix(p_q.red,   n_q.red,   t_eff);
      mix_g_q   <= mix(p_q.green, n_q.green, t_eff);
      mix_b_q   <= mix(p_q.blue,  n_q.blue,  t_eff);
    end
  end

  // Pixel store: write divided blend, registered read for output
  always_ff @(posedge clk_i) begin
    if (mix_valid_q) begin
      px_mem[mix_idx_q] <= {div100(mix_b_q), div100(mix_g_q), div100(mix_r_q)};
    end
    if (e_issue) begin
      rd_px_q <= px_mem[e_idx_q[IdxW-1:0]];
      rd_ok_q <= px_ok_q[e_idx_q[IdxW-1:0]];
    end
  end

  // Written flags: unwritten pixels read as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_ok_q <= '0;
    end else if (mix_valid_q) begin
      px_ok_q[mix_idx_q] <= 1'b1;
    end
  end

  // Output register: one LED per cycle while the sink keeps up
  assign e_more  = e_idx_q < JW'(LedCount);
  assign e_issue = cmd_i.emit && e_more && (!out_valid_q || m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_idx_q     <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      if (cmd_i.emit_init) begin
        e_idx_q <= '0;
      end else if (e_issue) begin
        e_idx_q <= e_idx_q + JW'(1);
      end
      if (e_issue) begin
        out_valid_q <= 1'b1;
        out_idx_q   <= e_idx_q[IdxW-1:0];
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o       = out_valid_q;
  assign led_index_o     = IDX_W'(out_idx_q);
  assign led_red_o       = rd_ok_q ? rd_px_q[0*CH_W +: CH_W] : '0;
  assign led_green_o     = rd_ok_q ? rd_px_q[1*CH_W +: CH_W] : '0;
  assign led_blue_o      = rd_ok_q ? rd_px_q[2*CH_W +: CH_W] : '0;
  assign last_led_o      = out_idx_q == IdxW'(LedCount - 1);
  assign stops_dropped_o = ovf_q;

  // Status back to the controller
  assign k_plus            = (CW + 1)'(k_q) + (CW + 1)'(1);
  assign stat_o.count_zero = count_q == '0;
  assign stat_o.more_segs  = k_plus < (CW + 1)'(count_q);
  assign stat_o.div_done   = div_done;
  assign stat_o.sweep_done = sweep_done;
  assign stat_o.emit_done  = !e_more && !out_valid_q;

endmodule

### src/lsgr_ctrl.sv
// Controller state machine: collects stops, sequences segments and the output run.
module lsgr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            s_final_i,
  output logic            s_ready_o,
  input  lsgr_pkg::stat_t stat_i,
  output lsgr_pkg::cmd_t  cmd_o
);
  import lsgr_pkg::*;

  state_e state_q;
  state_e state_d;
  logic   accept;

  assign s_ready_o = state_q == ST_IDLE;
  assign accept    = s_valid_i && s_ready_o;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_final_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = stat_i.count_zero ? ST_DRAIN : ST_RD_P;
      end
      ST_RD_P:  state_d = ST_RD_N;
      ST_RD_N:  state_d = ST_SETUP;
      ST_SETUP: state_d = ST_DIV;
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (stat_i.sweep_done) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_d = stat_i.more_segs ? ST_RD_P : ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o       = '0;
    cmd_o.store = accept;
    unique case (state_q)
      ST_IDLE:  ;
      ST_START: cmd_o.seg_init = !stat_i.count_zero;
      ST_RD_P:  cmd_o.rd_p = 1'b1;
      ST_RD_N:  cmd_o.rd_n = 1'b1;
      ST_SETUP: cmd_o.setup = 1'b1;
      ST_DIV:   ;
      ST_SWEEP: cmd_o.sweep = 1'b1;
      ST_NEXT:  cmd_o.seg_next = stat_i.more_segs;
      ST_DRAIN: cmd_o.emit_init = 1'b1;
      ST_EMIT: begin
        cmd_o.emit   = 1'b1;
        cmd_o.finish = stat_i.emit_done;
      end
      default: ;
    endcase
  end

endmodule

### src/led_strip_gradient_render_top.sv
// Top level of the LED strip gradient renderer: stream ports, controller and datapath.
// A stop that is not final is taken while ready is high, produces no item, and ready stays high.
// A final stop renders segment by segment: for each stop pair, two stop reads, setup,
// a divider run for the step size, a sweep over the segment's LEDs, and the next segment.
// Then LedCount output items follow at one per cycle while the sink keeps up, set by the single pixel store read port.
// Reset (asynchronous, active low) empties the stop store; per-LED flags make every pixel black.
module led_strip_gradient_render_top #(
  parameter int LedCount = lsgr_pkg::LED_COUNT_DEF,
  parameter int MaxStops = lsgr_pkg::MAX_STOPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // stop_percent, stop_red, stop_green, stop_blue, zero pad
  input  logic        s_axis_tlast,   // final_stop
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // led_index, led_red, led_green, led_blue, zero pad
  output logic        m_axis_tlast,   // last_led
  output logic        m_axis_tuser    // stops_dropped
);
  import lsgr_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [IDX_W-1:0]  led_index;
  logic [CH_W-1:0]   led_red;
  logic [CH_W-1:0]   led_green;
  logic [CH_W-1:0]   led_blue;

  lsgr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_final_i (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lsgr_dp #(
    .LedCount (LedCount),
    .MaxStops (MaxStops)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .stop_i          (stop_t'(s_axis_tdata[30:0])),
    .m_ready_i       (m_axis_tready),
    .m_valid_o       (m_axis_tvalid),
    .led_index_o     (led_index),
    .led_red_o       (led_red),
    .led_green_o     (led_green),
    .led_blue_o      (led_blue),
    .last_led_o      (m_axis_tlast),
    .stops_dropped_o (m_axis_tuser)
  );

  // Pack the output item
  assign m_axis_tdata = {2'b00, led_blue, led_green, led_red, led_index};

`ifndef SYNTHESIS
  // Never take stops while a rendered run is being delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input ready while output item pending");

  // A final stop closes the input until its run is out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still ready after final stop");

  // Once the last LED is taken, the block is ready for stops again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |-> ##2 s_axis_tready)
    else $error("input not reopened after last LED");
`endif

endmodule
